FILE: design/assert_macros.svh
// assertion macros used by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/fnvht_pkg.sv
// ----------------------------------------------------------------------------
// fnvht_pkg
// shared types and constants of the fnv-1a bucketed hash table
// ----------------------------------------------------------------------------
package fnvht_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_ZERO      = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL,
      S_QUOT,
      S_REM,
      S_READ,
      S_SCAN,
      S_WRITE,
      S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;  // write zero to row at clear counter
      logic take_byte;   // latch input item
      logic do_mul;      // finish hash multiply
      logic do_quot;     // bucket quotient estimate
      logic do_rem;      // bucket remainder
      logic do_read;     // issue row read
      logic do_scan;     // compare row, choose slot
      logic do_write;    // write row back
      logic load_out;    // capture result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_last;
      logic need_write;
   } sts_type;

endpackage

FILE: design/fnvht_ctrl.sv
// ----------------------------------------------------------------------------
// fnvht_ctrl
// sequencer: clearing pass, byte fold, row read, scan, write, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fnvht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fnvht_pkg::sts_type sts,
   output fnvht_pkg::cmd_type cmd
);

   fnvht_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fnvht_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         fnvht_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = fnvht_pkg::S_IDLE;
         end
         fnvht_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               state_in = fnvht_pkg::S_MUL;
            end
         end
         fnvht_pkg::S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in = sts.is_last ? fnvht_pkg::S_QUOT : fnvht_pkg::S_IDLE;
         end
         fnvht_pkg::S_QUOT: begin
            cmd.do_quot = 1'b1;
            state_in = fnvht_pkg::S_REM;
         end
         fnvht_pkg::S_REM: begin
            cmd.do_rem = 1'b1;
            state_in = fnvht_pkg::S_READ;
         end
         fnvht_pkg::S_READ: begin
            cmd.do_read = 1'b1;
            state_in = fnvht_pkg::S_SCAN;
         end
         fnvht_pkg::S_SCAN: begin
            cmd.do_scan = 1'b1;
            state_in = sts.need_write ? fnvht_pkg::S_WRITE : fnvht_pkg::S_OUT;
         end
         fnvht_pkg::S_WRITE: begin
            cmd.do_write = 1'b1;
            state_in = fnvht_pkg::S_OUT;
         end
         fnvht_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = fnvht_pkg::S_IDLE;
            end
         end
         default: state_in = fnvht_pkg::S_IDLE;
      endcase
   end

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_ready, state_ff == fnvht_pkg::S_IDLE)
   `ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_valid)
   `ASSERT_NEXT(a_write_out, clock, reset, cmd.do_write, state_ff == fnvht_pkg::S_OUT)
   `ASSERT_IMPLIES(a_no_ready_clear, clock, reset, state_ff == fnvht_pkg::S_CLEAR, !req_ready)

endmodule

FILE: design/fnvht_datapath.sv
// ----------------------------------------------------------------------------
// fnvht_datapath
// hash register, bucket row memories, slot scan and result register
// ----------------------------------------------------------------------------
module fnvht_datapath #(
   parameter int BUCKETS = 128,
   parameter int SLOTS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  fnvht_pkg::cmd_type cmd,
   output fnvht_pkg::sts_type sts,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_key_byte,
   input  logic               req_byte_valid,
   input  logic               req_last_byte,
   input  logic [31:0]        req_stored_value,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_found_value,
   output logic [31:0]        rsp_key_hash
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROWW = SLOTS * 32;

   // one row holds all slots of a bucket
   logic [ROWW-1:0] hash_mem [BUCKETS];
   logic [ROWW-1:0] val_mem  [BUCKETS];

   logic [31:0]     run_ff, run_in;
   logic [31:0]     xor_ff;
   logic            valid_ff, last_ff;
   logic [1:0]      op_ff;
   logic [31:0]     value_ff;
   logic [31:0]     h_ff;
   logic [BW-1:0]   bucket;
   logic [ROWW-1:0] hrow_ff, vrow_ff;
   logic [BW:0]     clr_ff;
   logic [SW-1:0]   slot_ff;
   logic [1:0]      status_ff;
   logic [31:0]     found_ff;
   logic [1:0]      out_status_ff;
   logic [31:0]     out_found_ff, out_hash_ff;

   logic [31:0]     product;
   logic            hit_any, empty_any;
   logic [SW-1:0]   hit_idx, empty_idx;
   logic [ROWW-1:0] new_hrow, new_vrow;

   assign product = xor_ff * fnvht_pkg::FNV_PRIME;

   always_comb begin
      run_in = run_ff;
      if (cmd.do_mul) begin
         run_in = valid_ff ? product : run_ff;
         if (last_ff) run_in = fnvht_pkg::FNV_BASIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= fnvht_pkg::FNV_BASIS;
         clr_ff <= '0;
      end else begin
         run_ff <= run_in;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         xor_ff   <= run_ff ^ {24'd0, req_key_byte};
         valid_ff <= req_byte_valid;
         last_ff  <= req_last_byte;
         op_ff    <= req_opcode;
         value_ff <= req_stored_value;
      end
      if (cmd.do_mul) begin
         h_ff <= valid_ff ? product : run_ff;
      end
   end

   // hash modulo bucket count
   generate
      if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
         // power of two: the low hash bits pick the bucket
         assign bucket = (BUCKETS > 1) ? h_ff[BW-1:0] : '0;
      end else begin : g_recip
         // reciprocal quotient is exact or one low, one compare and subtract
         // finishes the remainder
         localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
         logic [63:0] qprod;
         logic [31:0] quot_ff;
         logic [31:0] rem_ff;
         logic [31:0] rem_fix;
         assign qprod = {32'd0, h_ff} * {32'd0, RECIP};
         always_ff @(posedge clock) begin
            if (cmd.do_quot) quot_ff <= qprod[63:32];
            if (cmd.do_rem)  rem_ff  <= h_ff - quot_ff * 32'(BUCKETS);
         end
         assign rem_fix = (rem_ff >= 32'(BUCKETS)) ? rem_ff - 32'(BUCKETS) : rem_ff;
         assign bucket  = rem_fix[BW-1:0];
      end
   endgenerate

   // memories: clearing pass writes zero hash rows
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         hash_mem[clr_ff[BW-1:0]] <= '0;
      end else if (cmd.do_write) begin
         hash_mem[bucket] <= new_hrow;
         val_mem[bucket]  <= new_vrow;
      end
      if (cmd.do_read) begin
         hrow_ff <= hash_mem[bucket];
         vrow_ff <= val_mem[bucket];
      end
   end

   assign sts.clear_done = (clr_ff == (BW+1)'(BUCKETS - 1));
   assign sts.is_last    = last_ff;
   assign sts.need_write = (op_ff != fnvht_pkg::OP_NONE) && (h_ff != 32'd0) &&
                           ((op_ff == fnvht_pkg::OP_INSERT) ? empty_any :
                            ((op_ff == fnvht_pkg::OP_REMOVE) && hit_any));

   // priority search over the slots of the row
   always_comb begin
      hit_any = 1'b0;
      empty_any = 1'b0;
      hit_idx = '0;
      empty_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hrow_ff[i*32 +: 32] == h_ff) begin
            hit_any = 1'b1;
            hit_idx = SW'(i);
         end
         if (hrow_ff[i*32 +: 32] == 32'd0) begin
            empty_any = 1'b1;
            empty_idx = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_scan) begin
         found_ff <= 32'd0;
         status_ff <= fnvht_pkg::ST_NOT_FOUND;
         if (op_ff == fnvht_pkg::OP_NONE) begin
            status_ff <= fnvht_pkg::ST_NOT_FOUND;
         end else if (h_ff == 32'd0) begin
            status_ff <= fnvht_pkg::ST_ZERO;
         end else if (op_ff == fnvht_pkg::OP_INSERT) begin
            if (empty_any) begin
               status_ff <= fnvht_pkg::ST_DONE;
               slot_ff <= empty_idx;
            end else begin
               status_ff <= fnvht_pkg::ST_FULL;
            end
         end else if (hit_any) begin
            status_ff <= fnvht_pkg::ST_DONE;
            found_ff <= vrow_ff[hit_idx*32 +: 32];
            slot_ff <= hit_idx;
         end
      end
   end

   always_comb begin
      new_hrow = hrow_ff;
      new_vrow = vrow_ff;
      if (op_ff == fnvht_pkg::OP_INSERT) begin
         new_hrow[slot_ff*32 +: 32] = h_ff;
         new_vrow[slot_ff*32 +: 32] = value_ff;
      end else begin
         new_hrow[slot_ff*32 +: 32] = 32'd0;
         new_vrow[slot_ff*32 +: 32] = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_found_ff  <= found_ff;
         out_hash_ff   <= h_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_found_value = out_found_ff;
   assign rsp_key_hash    = out_hash_ff;

endmodule

FILE: design/fnv1a_bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// fnv1a_bucketed_hash_table
// fnv-1a keyed table of hashes and values, one row of slots per bucket
// ----------------------------------------------------------------------------
// usage
// - req channel carries one key byte per item; last_byte ends the key and
//   runs the opcode (insert, find, remove) on bucket hash mod BUCKETS
// - rsp channel gives one item per key: status, found value, key hash
// - a byte that is not last is latched, then folded by the hash multiply
// - a last byte passes through latch, multiply, bucket quotient, bucket
//   remainder, row read, slot scan, optional row write and result load;
//   rsp_valid is registered at the result load; no new byte is taken until
//   the sequence returns to idle, and this sequencer sets the rate
// - after reset a clearing pass writes every bucket row empty, with
//   req_ready low
// - rsp has its own output register; if the receiver stalls the block still
//   takes key bytes, but the next result waits in the sequencer, with
//   req_ready low, until the old one is taken
// - slot values are not cleared at reset, only read through a matching hash
// ----------------------------------------------------------------------------
module fnv1a_bucketed_hash_table #(
   parameter int BUCKETS = 128,
   parameter int SLOTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_key_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   input  logic [31:0] req_stored_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_value,
   output logic [31:0] rsp_key_hash
);

   // command and status between sequencer and datapath
   fnvht_pkg::cmd_type cmd;
   fnvht_pkg::sts_type sts;

   fnvht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fnvht_datapath #(
      .BUCKETS (BUCKETS),
      .SLOTS   (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_key_byte     (req_key_byte),
      .req_byte_valid   (req_byte_valid),
      .req_last_byte    (req_last_byte),
      .req_stored_value (req_stored_value),
      .rsp_status       (rsp_status),
      .rsp_found_value  (rsp_found_value),
      .rsp_key_hash     (rsp_key_hash)
   );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// randomised check of the fnv-1a bucketed hash table against its own predictor
// ----------------------------------------------------------------------------
module tb_top;

   localparam int BUCKETS  = 128;
   localparam int SLOTS    = 8;
   localparam int N_RANDOM = 400;
   localparam int WATCHDOG = 20000;

   // one key byte item as sent on the request channel
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  key_byte;
      logic        byte_valid;
      logic        last_byte;
      logic [31:0] stored_value;
   } key_item_type;

   // one table answer
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [31:0] key_hash;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = fnvht_pkg::OP_INSERT;
   logic [7:0]  req_key_byte = '0;
   logic        req_byte_valid = 1'b0;
   logic        req_last_byte = 1'b0;
   logic [31:0] req_stored_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_value;
   logic [31:0] rsp_key_hash;

   fnv1a_bucketed_hash_table #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) dut (.*);

   always #4 clock = ~clock;

   // predictor state: running hash and a shadow of the table
   logic [31:0] pred_hash;
   logic [31:0] shadow_hash [BUCKETS*SLOTS];
   logic [31:0] shadow_value [BUCKETS*SLOTS];

   key_item_type pending_items[$];
   answer_type   expected_answers[$];
   int           mismatches = 0;
   bit           quiet = 1'b0;      // no idling in the last part
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           idle_cycles = 0;

   // fold one accepted item into the predictor
   function automatic void predict_table(input key_item_type it);
      logic [31:0] h;
      int          base;
      int          slot;
      answer_type  a;
      if (it.byte_valid)
         pred_hash = (pred_hash ^ {24'd0, it.key_byte}) * fnvht_pkg::FNV_PRIME;
      if (!it.last_byte) return;
      h = pred_hash;
      pred_hash = fnvht_pkg::FNV_BASIS;
      base = int'(h % BUCKETS) * SLOTS;
      a.status = fnvht_pkg::ST_NOT_FOUND;
      a.found_value = '0;
      a.key_hash = h;
      slot = -1;
      if (it.opcode == fnvht_pkg::OP_NONE) begin
         a.status = fnvht_pkg::ST_NOT_FOUND;
      end else if (h == 0) begin
         a.status = fnvht_pkg::ST_ZERO;
      end else if (it.opcode == fnvht_pkg::OP_INSERT) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (shadow_hash[base+i] == 0) slot = i;
         if (slot < 0) begin
            a.status = fnvht_pkg::ST_FULL;
         end else begin
            shadow_hash[base+slot] = h;
            shadow_value[base+slot] = it.stored_value;
            a.status = fnvht_pkg::ST_DONE;
         end
      end else begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (shadow_hash[base+i] == h) slot = i;
         if (slot >= 0) begin
            a.found_value = shadow_value[base+slot];
            a.status = fnvht_pkg::ST_DONE;
            if (it.opcode == fnvht_pkg::OP_REMOVE) shadow_hash[base+slot] = '0;
         end
      end
      expected_answers.push_back(a);
   endfunction

   // driver: next item is loaded only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_table(
            {req_opcode, req_key_byte, req_byte_valid, req_last_byte, req_stored_value});
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap <= int'($urandom_range(1, 8));
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               key_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_opcode <= it.opcode;
               req_key_byte <= it.key_byte;
               req_byte_valid <= it.byte_valid;
               req_last_byte <= it.last_byte;
               req_stored_value <= it.stored_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: result side stalls in bursts and checks every answer taken
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected answer hash %h", rsp_key_hash);
            end else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_found_value !== e.found_value ||
                   rsp_key_hash !== e.key_hash) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st %0d val %h hash %h, got st %0d val %h hash %h",
                              e.status, e.found_value, e.key_hash,
                              rsp_status, rsp_found_value, rsp_key_hash);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap <= int'($urandom_range(1, 8));
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   // queue a whole key as byte items; last item carries opcode and value
   task automatic send_key(input logic [7:0] kb[$], input logic [1:0] op,
                           input logic [31:0] val);
      key_item_type it;
      for (int i = 0; i < kb.size(); i++) begin
         it.opcode = 2'($urandom_range(0, 3));
         it.key_byte = kb[i];
         it.byte_valid = 1'b1;
         it.last_byte = (i == kb.size() - 1);
         it.stored_value = $urandom;
         if (it.last_byte) begin
            it.opcode = op;
            it.stored_value = val;
         end
         // now and then a skipped byte inside the key
         if (!it.last_byte && $urandom_range(0, 7) == 0) begin
            key_item_type skip;
            skip = it;
            skip.byte_valid = 1'b0;
            skip.key_byte = 8'($urandom);
            pending_items.push_back(skip);
         end
         pending_items.push_back(it);
      end
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   logic [7:0]   key[$];
   logic [7:0]   pool[8][$];
   key_item_type it;
   logic [15:0]  bucket_key[$];

   initial begin
      pred_hash = fnvht_pkg::FNV_BASIS;
      foreach (shadow_hash[i]) begin
         shadow_hash[i] = '0;
         shadow_value[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty key with every opcode
      it = '{opcode: fnvht_pkg::OP_INSERT, key_byte: 8'hFF, byte_valid: 1'b0,
             last_byte: 1'b1, stored_value: 32'hFFFF_FFFF};
      pending_items.push_back(it);
      it.opcode = fnvht_pkg::OP_FIND;     pending_items.push_back(it);
      it.opcode = fnvht_pkg::OP_NONE;     pending_items.push_back(it);
      it.opcode = fnvht_pkg::OP_REMOVE;   pending_items.push_back(it);
      it.opcode = fnvht_pkg::OP_REMOVE;   pending_items.push_back(it);
      // extremes of the byte, find of a missing key
      key = '{8'h00};          send_key(key, fnvht_pkg::OP_FIND, 32'd0);
      key = '{8'hFF, 8'h00};   send_key(key, fnvht_pkg::OP_INSERT, 32'd0);
      key = '{8'hFF, 8'h00};   send_key(key, fnvht_pkg::OP_FIND, 32'd0);
      key = '{8'hFF, 8'h00};   send_key(key, fnvht_pkg::OP_NONE, 32'd5);
      // zero hash: four bytes whose fnv-1a hash is zero
      key = '{8'hCC, 8'h24, 8'h31, 8'hC4}; send_key(key, fnvht_pkg::OP_INSERT, 32'h1234);
      key = '{8'hCC, 8'h24, 8'h31, 8'hC4}; send_key(key, fnvht_pkg::OP_FIND, 32'h0);
      // fill one bucket past full: two-byte keys that land in bucket zero
      bucket_key = {};
      for (int b = 0; b < 65536 && bucket_key.size() < SLOTS + 1; b++) begin
         logic [31:0] h;
         h = ((fnvht_pkg::FNV_BASIS ^ {24'd0, 8'(b >> 8)}) * fnvht_pkg::FNV_PRIME ^
              {24'd0, 8'(b)}) * fnvht_pkg::FNV_PRIME;
         if (h % BUCKETS == 0) bucket_key.push_back(16'(b));
      end
      // sender waits here until every answer has come
      wait_drained();
      foreach (bucket_key[i]) begin
         key = '{bucket_key[i][15:8], bucket_key[i][7:0]};
         send_key(key, fnvht_pkg::OP_INSERT, $urandom);
      end
      key = '{bucket_key[0][15:8], bucket_key[0][7:0]};
      send_key(key, fnvht_pkg::OP_REMOVE, 32'd0);
      send_key(key, fnvht_pkg::OP_FIND, 32'd0);
      wait_drained();

      // random part: a small pool of keys so finds and removes hit
      foreach (pool[p]) begin
         pool[p] = {};
         repeat ($urandom_range(1, 4)) pool[p].push_back(8'($urandom));
      end
      for (int n = 0; n < N_RANDOM;) begin
         int r;
         r = int'($urandom_range(0, 19));
         if (r == 0) begin
            it = '{opcode: 2'($urandom_range(0, 3)), key_byte: 8'($urandom),
                   byte_valid: 1'($urandom_range(0, 1)), last_byte: 1'b1,
                   stored_value: rand_value()};
            pending_items.push_back(it);
            n++;
         end else begin
            logic [1:0] op;
            if (r < 8) op = fnvht_pkg::OP_INSERT;
            else if (r < 14) op = fnvht_pkg::OP_FIND;
            else if (r < 19) op = fnvht_pkg::OP_REMOVE;
            else op = fnvht_pkg::OP_NONE;
            if ($urandom_range(0, 4) == 0) begin
               key = {};
               repeat ($urandom_range(1, 5)) key.push_back(8'($urandom));
            end else begin
               key = pool[$urandom_range(0, 7)];
            end
            send_key(key, op, rand_value());
            n += key.size();
         end
         if (n > N_RANDOM * 3 / 4) quiet = 1'b1;
         while (pending_items.size() > 16) @(posedge clock);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/fnvht_pkg.sv
design/fnvht_ctrl.sv
design/fnvht_datapath.sv
design/fnv1a_bucketed_hash_table.sv
verif/tb_top.sv
